FILE: rtl/sorted_timeout_queue_defines.svh
// assertion macros for the sorted timeout queue
// used by modules that carry concurrent checks, no other dependencies
`ifndef SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`define SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("stq assertion failed");
`define STQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("stq forbidden condition");
`else
`define STQ_ASSERT(lbl, clk, rstn, prop)
`define STQ_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/stq_pkg.sv
// shared types and constants for the sorted timeout queue
// no dependencies
package stq_pkg;
  localparam int DepthDef    = 16;
  localparam int TickBitsDef = 24;
  localparam int DelayW      = 16;
  localparam int ProdW       = 24;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;

  localparam logic CFG_DIV = 1'b0;
  localparam logic CFG_MUL = 1'b1;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       mul;
    logic       div_take;
    logic       insert;
    logic       cancel;
    logic       dec;
    logic       pop;
    logic       emit;
    logic       id_head;
    logic [2:0] status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       unit;
    logic       full;
    logic       found;
    logic       head_zero;
    logic       next_zero;
    logic       out_free;
    logic       div_done;
  } sts_t;
endpackage

FILE: rtl/stq_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on stq_pkg
module stq_div import stq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DelayW-1:0] dividend_i,
  input  logic [7:0]        divisor_i,
  output logic              done_o,
  output logic [DelayW-1:0] quotient_o
);
  localparam int CntW = $clog2(DelayW);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        rem_q, rem_d, dv_q, dv_d;
  logic [DelayW-1:0] quo_q, quo_d;
  logic [8:0]        trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DelayW-1]};
  assign ge    = trial >= {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      // zero divisor acts as one
      dv_d   = (divisor_i == 8'd0) ? 8'd1 : divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 8'(trial - {1'b0, dv_q}) : trial[7:0];
      quo_d = {quo_q[DelayW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DelayW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

FILE: rtl/stq_ctrl.sv
// control state machine: sequences add, cancel and tick beats
// depends on stq_pkg and the assertion macros
`include "sorted_timeout_queue_defines.svh"
module stq_ctrl import stq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.op)
          OP_ADD: begin
            if (sts_i.full) begin
              if (sts_i.out_free) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = ST_FULL;
                cmd_o.last   = 1'b1;
                state_d      = S_IDLE;
              end
            end else if (sts_i.unit) begin
              cmd_o.mul = 1'b1;
              state_d   = S_INS;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          OP_CANCEL: begin
            if (sts_i.out_free) begin
              cmd_o.cancel = 1'b1;
              cmd_o.emit   = 1'b1;
              cmd_o.status = sts_i.found ? ST_CANCELLED : ST_NOTFOUND;
              cmd_o.last   = 1'b1;
              state_d      = S_IDLE;
            end
          end
          OP_TICK: begin
            cmd_o.dec = 1'b1;
            state_d   = S_EMIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.insert = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_ADDED;
          cmd_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!sts_i.head_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          // expired entries form the head of the list, one per beat
          cmd_o.pop     = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.id_head = 1'b1;
          cmd_o.status  = ST_EXPIRED;
          cmd_o.last    = !sts_i.next_zero;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `STQ_ASSERT(a_emit_free, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_free)
  `STQ_ASSERT(a_pop_head, clk_i, rst_ni, cmd_o.pop |-> sts_i.head_zero)
  `STQ_NEVER(a_ins_full, clk_i, rst_ni, cmd_o.insert && sts_i.full)
  `STQ_ASSERT(a_div_ins, clk_i, rst_ni,
              (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_INS))
endmodule

FILE: rtl/stq_dp.sv
// datapath: config registers, both sorted lists, tick conversion, output register
// depends on stq_pkg and stq_div
module stq_dp import stq_pkg::*; #(
  parameter int DEPTH     = DepthDef,
  parameter int TICK_BITS = TickBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [1:0]        opcode_i,
  input  logic              unit_i,
  input  logic [7:0]        event_id_i,
  input  logic [DelayW-1:0] delay_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              out_unit_o,
  output logic [7:0]        out_event_id_o,
  output logic              last_o
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = 34;
  localparam logic [WW-1:0] TickMax = (WW'(1) << TICK_BITS) - WW'(1);

  logic [7:0]           div_q, mul_q;
  logic [1:0]           op_q;
  logic                 unit_q;
  logic [7:0]           id_q;
  logic [DelayW-1:0]    delay_q;
  logic [TICK_BITS-1:0] t_q, t_d;
  logic [TICK_BITS-1:0] ticks_q [2][DEPTH];
  logic [TICK_BITS-1:0] ticks_d [2][DEPTH];
  logic [7:0]           ids_q   [2][DEPTH];
  logic [7:0]           ids_d   [2][DEPTH];
  logic [CW-1:0]        cnt_q [2];
  logic [CW-1:0]        cnt_d [2];
  logic                 ov_q;
  logic [2:0]           ost_q;
  logic                 ou_q, ol_q;
  logic [7:0]           oid_q;
  logic                 div_done;
  logic [DelayW-1:0]    quo;
  logic [ProdW-1:0]     prod;
  logic [WW-1:0]        raw;
  logic [DEPTH-1:0]     ins, match, first, ge;
  logic [CW-1:0]        cnt;

  stq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (delay_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign prod = ProdW'(delay_q) * ProdW'(mul_q);
  assign raw  = cmd_i.mul ? WW'(prod) : WW'(quo);
  assign cnt  = cnt_q[unit_q];

  // zero counts as one tick, too wide saturates
  always_comb begin
    t_d = t_q;
    if (cmd_i.mul || cmd_i.div_take) begin
      if (raw == '0) begin
        t_d = TICK_BITS'(1);
      end else if (raw > TickMax) begin
        t_d = TICK_BITS'(TickMax);
      end else begin
        t_d = TICK_BITS'(raw);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins[i]   = (CW'(i) >= cnt) || (ticks_q[unit_q][i] > t_q);
      match[i] = (CW'(i) < cnt) && (ids_q[unit_q][i] == id_q);
    end
    first = match & (~match + DEPTH'(1));
    ge    = ~(first - DEPTH'(1));
  end

  always_comb begin
    ticks_d = ticks_q;
    ids_d   = ids_q;
    cnt_d   = cnt_q;
    if (cmd_i.insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
          ticks_d[unit_q][i] = ticks_q[unit_q][(i > 0) ? i - 1 : 0];
          ids_d[unit_q][i]   = ids_q[unit_q][(i > 0) ? i - 1 : 0];
        end else if (ins[i]) begin
          ticks_d[unit_q][i] = t_q;
          ids_d[unit_q][i]   = id_q;
        end
      end
      cnt_d[unit_q] = cnt + 1'b1;
    end else if (cmd_i.cancel) begin
      for (int i = 0; i + 1 < DEPTH; i++) begin
        if (ge[i]) begin
          ticks_d[unit_q][i] = ticks_q[unit_q][i + 1];
          ids_d[unit_q][i]   = ids_q[unit_q][i + 1];
        end
      end
      if (|match) cnt_d[unit_q] = cnt - 1'b1;
    end else if (cmd_i.dec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) < cnt && ticks_q[unit_q][i] != '0) begin
          ticks_d[unit_q][i] = ticks_q[unit_q][i] - 1'b1;
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i + 1 < DEPTH; i++) begin
        ticks_d[unit_q][i] = ticks_q[unit_q][i + 1];
        ids_d[unit_q][i]   = ids_q[unit_q][i + 1];
      end
      cnt_d[unit_q] = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= 8'd10;
      mul_q <= 8'd100;
      cnt_q <= '{default: '0};
      ov_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIV: div_q <= cfg_data_i;
          CFG_MUL: mul_q <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q <= ticks_d;
    ids_q   <= ids_d;
    t_q     <= t_d;
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      unit_q  <= unit_i;
      id_q    <= event_id_i;
      delay_q <= delay_i;
    end
    if (cmd_i.emit) begin
      ost_q <= cmd_i.status;
      ou_q  <= unit_q;
      oid_q <= cmd_i.id_head ? ids_q[unit_q][0] : id_q;
      ol_q  <= cmd_i.last;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.unit      = unit_q;
  assign sts_o.full      = (cnt == CW'(DEPTH));
  assign sts_o.found     = |match;
  assign sts_o.head_zero = (cnt != '0) && (ticks_q[unit_q][0] == '0);
  assign sts_o.next_zero = (cnt > CW'(1)) && (ticks_q[unit_q][1] == '0);
  assign sts_o.out_free  = !ov_q || !out_stall_i;
  assign sts_o.div_done  = div_done;

  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign out_unit_o     = ou_q;
  assign out_event_id_o = oid_q;
  assign last_o         = ol_q;
endmodule

FILE: rtl/sorted_timeout_queue.sv
// channel  | handshake              | payload
// in       | in_valid_i/in_stall_o   | opcode_i unit_i event_id_i delay_i
// out      | out_valid_o/out_stall_i | status_o out_unit_o out_event_id_o last_o
// cfg      | cfg_we_i                | cfg_idx_i cfg_data_i
// one item at a time: accept, decode, then the operation itself
// add: ms delays are scaled by the multiplier, us delays wait on the bit-serial divider, a full list gets ST_FULL
// cancel: removed in the decode state; tick: decrement every entry, then pop one expired entry per beat
// a stalled output register holds the sequencer until the beat is taken
// reset clears both lists and loads divisor 10 and multiplier 100
module sorted_timeout_queue import stq_pkg::*; #(
  parameter int DEPTH     = DepthDef,
  parameter int TICK_BITS = TickBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic              unit_i,
  input  logic [7:0]        event_id_i,
  input  logic [DelayW-1:0] delay_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              out_unit_o,
  output logic [7:0]        out_event_id_o,
  output logic              last_o
);
  cmd_t cmd;
  sts_t sts;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stq_dp #(
    .DEPTH     (DEPTH),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .unit_i         (unit_i),
    .event_id_i     (event_id_i),
    .delay_i        (delay_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_unit_o     (out_unit_o),
    .out_event_id_o (out_event_id_o),
    .last_o         (last_o)
  );
endmodule
